// ----- hdl/crc24k_pkg.sv -----
package crc24k_pkg;

  // Key and seed lengths in bytes; one cell per byte
  localparam int unsigned KEY_BYTES  = 8;
  localparam int unsigned SEED_BYTES = 8;
  localparam int unsigned NUM_CELLS  = KEY_BYTES + SEED_BYTES;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned SEED_W  = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned HASH_W  = 24;
  localparam int unsigned ORDER_W = 2;
  localparam int unsigned CFG_W   = 64;

  // OpenPGP CRC-24: initial value and polynomial without its top bit
  localparam logic [HASH_W-1:0] CRC_INIT = 24'hB704CE;
  localparam logic [HASH_W-1:0] CRC_POLY = 24'h864CFB;

  // Order codes, two's complement
  localparam logic [ORDER_W-1:0] ORDER_GT = 2'b01;
  localparam logic [ORDER_W-1:0] ORDER_LT = 2'b11;
  localparam logic [ORDER_W-1:0] ORDER_EQ = 2'b00;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SEED_BYTES = 2'd0,
    CFG_SEED_COUNT = 2'd1
  } cfg_reg_e;

  // Payload handed from cell to cell
  typedef struct packed {
    logic [HASH_W-1:0] crc_a;
    logic [HASH_W-1:0] crc_b;
    logic [KEY_W-1:0]  rest_a;
    logic [KEY_W-1:0]  rest_b;
  } cell_t;

  // One byte of bitwise CRC-24, MSB first
  function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc,
                                                 input logic [7:0] data);
    logic [HASH_W-1:0] c;
    logic              top;
    c = crc ^ {data, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      top = c[HASH_W-1];
      c   = {c[HASH_W-2:0], 1'b0} ^ (top ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

// ----- hdl/crc24k_cell.sv -----
module crc24k_cell
  import crc24k_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  cell_t       stage_i,
  input  logic        from_key_i,
  input  logic        apply_i,
  input  logic [7:0]  seed_byte_i,
  output logic        valid_o,
  output cell_t       stage_o
);

  logic       valid_q;
  cell_t      stage_q;
  cell_t      stage_d;
  logic [7:0] byte_a;
  logic [7:0] byte_b;

  // Pick this cell's byte: next key byte or a seed byte
  always_comb begin
    byte_a = from_key_i ? stage_i.rest_a[7:0] : seed_byte_i;
    byte_b = from_key_i ? stage_i.rest_b[7:0] : seed_byte_i;
  end

  // Fold one byte into both running CRCs when apply_i is set, and drop the consumed key byte
  always_comb begin
    stage_d.crc_a  = apply_i ? crc_byte(stage_i.crc_a, byte_a) : stage_i.crc_a;
    stage_d.crc_b  = apply_i ? crc_byte(stage_i.crc_b, byte_b) : stage_i.crc_b;
    stage_d.rest_a = stage_i.rest_a >> 8;
    stage_d.rest_b = stage_i.rest_b >> 8;
  end

  // Advance the valid flag when the chain moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload on stall
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- hdl/crc24k_out.sv -----
module crc24k_out
  import crc24k_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  cell_t               stage_i,
  output logic                en_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [HASH_W-1:0]   hash_a_o,
  output logic [HASH_W-1:0]   hash_b_o,
  output logic [ORDER_W-1:0]  order_o
);

  logic               valid_q;
  logic [HASH_W-1:0]  hash_a_q;
  logic [HASH_W-1:0]  hash_b_q;
  logic [ORDER_W-1:0] order_q;
  logic [ORDER_W-1:0] order_d;

  // The chain moves whenever the output register is empty or being drained
  assign en_o = !valid_q || ready_i;

  // Compare the finished hashes
  always_comb begin
    if (stage_i.crc_a > stage_i.crc_b) begin
      order_d = ORDER_GT;
    end else if (stage_i.crc_b > stage_i.crc_a) begin
      order_d = ORDER_LT;
    end else begin
      order_d = ORDER_EQ;
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      hash_a_q <= stage_i.crc_a;
      hash_b_q <= stage_i.crc_b;
      order_q  <= order_d;
    end
  end

  assign valid_o  = valid_q;
  assign hash_a_o = hash_a_q;
  assign hash_b_o = hash_b_q;
  assign order_o  = order_q;

endmodule

// ----- hdl/seeded_crc24_key_comparator.sv -----
// Seeded CRC-24 key comparator. Each transaction on the slave stream carries
// two 64-bit keys; each key is hashed with the OpenPGP CRC-24 (init 0xB704CE,
// poly 0x1864CFB, no final xor), fed least significant byte first, then
// continued over the first seed_count bytes of seed_bytes (byte 0 in bits
// 7:0, counts above 8 act as 8). The master stream returns both hashes and
// their order (+1, -1 or 0). A row of 16 cells, one per key or seed byte,
// folds one byte per cycle into both CRCs, followed by a compare and output
// register: a new key pair is taken every cycle, and the whole row stalls
// only while a result waits in the output register.
// Configuration register 0 is seed_bytes, register 1 is seed_count; write
// them only while no transaction is in flight.
module seeded_crc24_key_comparator
  import crc24k_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // Key pair input
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // [63:0] key_a, [127:64] key_b
  // Result output
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [55:0]   m_axis_tdata,  // [23:0] hash_a, [47:24] hash_b,
                                       // [49:48] order, [55:50] zero
  // Configuration writes
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i
);

  logic [SEED_W-1:0]  seed_bytes_q;
  logic [COUNT_W-1:0] seed_count_q;
  logic               en;
  logic               valid_w [NUM_CELLS+1];
  cell_t              stage_w [NUM_CELLS+1];
  logic [HASH_W-1:0]  hash_a;
  logic [HASH_W-1:0]  hash_b;
  logic [ORDER_W-1:0] order;

  // Configuration registers, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_bytes_q <= '0;
      seed_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SEED_BYTES: seed_bytes_q <= cfg_data_i;
        CFG_SEED_COUNT: seed_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Feed the head of the chain
  assign s_axis_tready = en;
  assign valid_w[0]    = s_axis_tvalid;
  always_comb begin
    stage_w[0].crc_a  = CRC_INIT;
    stage_w[0].crc_b  = CRC_INIT;
    stage_w[0].rest_a = s_axis_tdata[KEY_W-1:0];
    stage_w[0].rest_b = s_axis_tdata[2*KEY_W-1:KEY_W];
  end

  // Row of byte cells: key bytes first, then seed bytes
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    if (g < KEY_BYTES) begin : g_key
      crc24k_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .en_i        (en),
        .valid_i     (valid_w[g]),
        .stage_i     (stage_w[g]),
        .from_key_i  (1'b1),
        .apply_i     (1'b1),
        .seed_byte_i (8'h00),
        .valid_o     (valid_w[g+1]),
        .stage_o     (stage_w[g+1])
      );
    end else begin : g_seed
      localparam int unsigned SeedIdx = g - KEY_BYTES;
      logic apply;
      // Seed byte j is used when j < seed_count; counts above the row saturate
      assign apply = seed_count_q > COUNT_W'(SeedIdx);
      crc24k_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .en_i        (en),
        .valid_i     (valid_w[g]),
        .stage_i     (stage_w[g]),
        .from_key_i  (1'b0),
        .apply_i     (apply),
        .seed_byte_i (seed_bytes_q[8*SeedIdx +: 8]),
        .valid_o     (valid_w[g+1]),
        .stage_o     (stage_w[g+1])
      );
    end
  end

  // Compare and output register
  crc24k_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_w[NUM_CELLS]),
    .stage_i  (stage_w[NUM_CELLS]),
    .en_o     (en),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .hash_a_o (hash_a),
    .hash_b_o (hash_b),
    .order_o  (order)
  );

  assign m_axis_tdata = {6'b000000, order, hash_b, hash_a};

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import crc24k_pkg::*;

  // OpenPGP CRC-24 start value and polynomial (implicit top bit)
  localparam logic [HASH_W-1:0] CRC24_START = 24'hB704CE;
  localparam logic [HASH_W-1:0] CRC24_TAPS  = 24'h864CFB;

  // Register indexes that do not exist; writes to them must be dropped
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE = 550;
  localparam int unsigned DRAIN_CYCLES    = 40;

  // Key patterns for the directed part
  localparam logic [63:0] K_ZERO  = 64'h0;
  localparam logic [63:0] K_ONES  = {64{1'b1}};
  localparam logic [63:0] K_RAMP  = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] K_PMAR  = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] K_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] K_ALT_5 = 64'h5555_5555_5555_5555;
  localparam logic [63:0] K_LSB   = 64'h1;
  localparam logic [63:0] K_MSB   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] K_C3    = 64'hC3C3_C3C3_C3C3_C3C3;
  localparam logic [63:0] K_BYTES = 64'h0706_0504_0302_0100;
  localparam logic [63:0] K_FF00  = 64'hFF00_FF00_FF00_FF00;
  localparam logic [63:0] K_00FF  = 64'h00FF_00FF_00FF_00FF;
  localparam logic [63:0] CNT_HI3 = 64'hFFFF_FFFF_FFFF_FFF3;

  typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [63:0] wdata;
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic        order_typed;
    logic [1:0]  order;
  } stim_row_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash_a;
    logic [HASH_W-1:0]  hash_b;
    logic [ORDER_W-1:0] order;
  } hash_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata = '0;  // [63:0] key_a, [127:64] key_b
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [55:0]   m_axis_tdata;   // [23:0] hash_a, [47:24] hash_b, [49:48] order
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = '0;
  logic [63:0]   cfg_data_i = '0;

  // Order typed in by a directed row travels along with its key pair
  logic          typed_order_on = 1'b0;
  logic [1:0]    typed_order = ORDER_EQ;

  // Shadow of the seed registers as the block should hold them
  logic [63:0]   seed_shadow = '0;
  logic [3:0]    seed_cnt_shadow = '0;

  hash_result_t  hash_results_q[$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   src_idle_pct = 37;
  int unsigned   sink_idle_pct = 74;

  stim_row_t dir_rows [27] = '{
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ZERO,  K_ZERO,  1'b1, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ONES,  K_ONES,  1'b1, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ZERO,  K_ONES,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ONES,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_RAMP,  K_PMAR,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ALT_A, K_ALT_5, 1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_LSB,   K_MSB,   1'b0, ORDER_EQ},
    // full seed length, seed still zero; then writes to missing registers
    '{ROW_CFG,  CFG_SEED_COUNT, 64'd8,   K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_CFG,  CFG_SPARE_2,    K_ONES,  K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_CFG,  CFG_SPARE_3,    K_ONES,  K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ZERO,  K_ONES,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_C3,    K_C3,    1'b1, ORDER_EQ},
    '{ROW_CFG,  CFG_SEED_BYTES, K_ONES,  K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ZERO,  K_ZERO,  1'b1, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ZERO,  K_ONES,  1'b0, ORDER_EQ},
    // counts above eight saturate
    '{ROW_CFG,  CFG_SEED_COUNT, 64'd15,  K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_RAMP,  K_PMAR,  1'b0, ORDER_EQ},
    '{ROW_CFG,  CFG_SEED_COUNT, 64'd9,   K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ALT_A, K_ALT_5, 1'b0, ORDER_EQ},
    // upper write data bits fall outside the count register
    '{ROW_CFG,  CFG_SEED_COUNT, CNT_HI3, K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_LSB,   K_MSB,   1'b0, ORDER_EQ},
    '{ROW_CFG,  CFG_SEED_BYTES, K_BYTES, K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_CFG,  CFG_SEED_COUNT, 64'd1,   K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_FF00,  K_00FF,  1'b0, ORDER_EQ},
    // zero count with a live seed: keys only
    '{ROW_CFG,  CFG_SEED_COUNT, 64'd0,   K_ZERO,  K_ZERO,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ZERO,  K_ONES,  1'b0, ORDER_EQ},
    '{ROW_PAIR, CFG_SEED_BYTES, K_ZERO,  K_ONES,  K_ONES,  1'b1, ORDER_EQ}
  };

  seeded_crc24_key_comparator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Fold one byte into the CRC, one data bit at a time, MSB first
  function automatic logic [HASH_W-1:0] crc24_shift_byte(input logic [HASH_W-1:0] crc,
                                                         input logic [7:0] data);
    logic [HASH_W-1:0] acc;
    logic              fb;
    acc = crc;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[HASH_W-1] ^ data[k];
      acc = {acc[HASH_W-2:0], 1'b0} ^ (fb ? CRC24_TAPS : '0);
    end
    return acc;
  endfunction

  // Key bytes low first, then the leading seed bytes
  function automatic logic [HASH_W-1:0] keyed_crc24(input logic [63:0] key);
    logic [HASH_W-1:0] crc;
    int unsigned       n_seed;
    crc    = CRC24_START;
    n_seed = (seed_cnt_shadow > 4'd8) ? 8 : seed_cnt_shadow;
    for (int i = 0; i < 8; i++)
      crc = crc24_shift_byte(crc, key[8*i +: 8]);
    for (int i = 0; i < n_seed; i++)
      crc = crc24_shift_byte(crc, seed_shadow[8*i +: 8]);
    return crc;
  endfunction

  function automatic hash_result_t predict_hashes(input logic [63:0] ka,
                                                  input logic [63:0] kb);
    hash_result_t r;
    r.hash_a = keyed_crc24(ka);
    r.hash_b = keyed_crc24(kb);
    if (r.hash_a > r.hash_b)
      r.order = ORDER_GT;
    else if (r.hash_b > r.hash_a)
      r.order = ORDER_LT;
    else
      r.order = ORDER_EQ;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Track register writes, predict accepted pairs, check returned results
  always @(posedge clk_i) begin
    hash_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SEED_BYTES: seed_shadow = cfg_data_i;
          CFG_SEED_COUNT: seed_cnt_shadow = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_hashes(s_axis_tdata[63:0], s_axis_tdata[127:64]);
        if (typed_order_on)
          want.order = typed_order;
        hash_results_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (hash_results_q.size() == 0) begin
          $error("result with nothing expected, tdata %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = hash_results_q.pop_front();
          check_field("hash_a", want.hash_a, m_axis_tdata[23:0]);
          check_field("hash_b", want.hash_b, m_axis_tdata[47:24]);
          check_field("order", 24'(want.order), 24'(m_axis_tdata[49:48]));
          check_field("pad", 24'h0, 24'(m_axis_tdata[55:50]));
        end
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

  // Drive one key pair, with a random gap in front; return at a falling edge
  task automatic send_pair(input logic [63:0] ka, input logic [63:0] kb,
                           input logic has_ord, input logic [1:0] ord);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid  <= 1'b1;
    s_axis_tdata   <= {kb, ka};
    typed_order_on <= has_ord;
    typed_order    <= ord;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Write a register once every pair in flight has come back
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (hash_results_q.size() != 0)
      @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [63:0] ka;
    logic [63:0] kb;
    logic [3:0]  cnt;
    int          reconf_left;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
      else
        send_pair(dir_rows[i].key_a, dir_rows[i].key_b,
                  dir_rows[i].order_typed, dir_rows[i].order);
    end

    reconf_left = $urandom_range(40, 160);
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 37 : (ph == 1) ? 74 : 0;
      sink_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 37 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Reprogram the seed now and then, extremes included
        if (reconf_left == 0) begin
          if ($urandom_range(0, 1))
            write_reg(CFG_SEED_BYTES, ($urandom_range(0, 7) == 0) ? K_ONES : rand_word());
          cnt = 4'($urandom_range(0, 15));
          case ($urandom_range(0, 5))
            0: cnt = 4'd0;
            1: cnt = 4'd8;
            2: cnt = 4'd15;
            default: ;
          endcase
          write_reg(CFG_SEED_COUNT, {60'(rand_word()), cnt});
          if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, rand_word());
          reconf_left = $urandom_range(40, 160);
        end
        reconf_left--;

        ka = rand_word();
        kb = rand_word();
        case ($urandom_range(0, 15))
          0: kb = ka;
          1: ka = $urandom_range(0, 1) ? K_ONES : K_ZERO;
          2: kb = ka ^ (64'd1 << $urandom_range(0, 63));
          default: ;
        endcase
        send_pair(ka, kb, 1'b0, ORDER_EQ);
      end
    end

    // Drain, then give stray results a chance to show up
    s_axis_tvalid <= 1'b0;
    sink_idle_pct = 0;
    while (hash_results_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Hang guard
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/crc24k_pkg.sv
hdl/crc24k_cell.sv
hdl/crc24k_out.sv
hdl/seeded_crc24_key_comparator.sv
tb/tb.sv
